// File: rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants of the 64-bit linear congruential generator.
// ----------------------------------------------------------------------------
package lcg_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int SPAN_W = 33;
	localparam int STEP_W = 6;

	localparam logic [WORD_W-1:0] LCG_MULT = 64'd6364136223846793005;
	localparam logic [WORD_W-1:0] LCG_INC  = 64'd1442695040888963407;

	typedef enum logic [2:0] {
		OP_NEXT_WORD = 3'd0,
		OP_NEXT_BYTE = 3'd1,
		OP_NEXT_INT  = 3'd2,
		OP_LOAD_SEED = 3'd3,
		OP_XOR_SEED  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [SPAN_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic              done;
		logic [HALF_W-1:0] remainder;
	} rem_rsp_t;

endpackage

// File: rtl/lcg64_random_generator_top.sv
// ----------------------------------------------------------------------------
// lcg64_random_generator_top
// 64-bit linear congruential generator: seed = seed * A + C mod 2^64, with
// word, byte and ranged-integer views of every advanced seed.
//
//   channel | dir | payload                                   | transfer
//   s_*     | in  | tuser: operation; tdata: operand, min, max | tvalid & tready
//   m_*     | out | tdata: word, byte, ranged value            | tvalid & tready
//
// Load and xor update the seed when accepted. An advance forms three 32x32
// partial products through one multiplier, then runs the remainder unit
// (one bit a cycle), then forms the result; the remainder unit is skipped
// when the range is empty. s_tready is low while an advance is in flight.
// A result waits in the output register until m_tready; a new item may be
// accepted meanwhile. Reset clears the seed to zero.
// ----------------------------------------------------------------------------
module lcg64_random_generator_top
	import lcg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // [2:0] operation
	input  logic [127:0] s_tdata,  // [63:0] operand, [95:64] min_value, [127:96] max_value
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata   // [63:0] random_word, [71:64] random_byte,
	                               // [103:72] ranged_value
);

	state_t state_q;
	state_t state_d;

	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] acc_d;
	logic [WORD_W-1:0] prod_q;
	logic [1:0]        cnt_q;
	logic [1:0]        part_q;
	logic [HALF_W-1:0] lo_q;
	logic [SPAN_W-1:0] span_q;
	logic              empty_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic [7:0]        byte_q;
	logic [HALF_W-1:0] ranged_q;

	logic              accept;
	logic              advance;
	logic              mul_last;
	logic              out_free;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [SPAN_W:0]   diff;

	op_t               op;
	logic signed [HALF_W-1:0] min_in;
	logic signed [HALF_W-1:0] max_in;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	assign op      = op_t'(s_tuser);
	assign min_in  = s_tdata[95:64];
	assign max_in  = s_tdata[127:96];
	assign accept  = s_tvalid && s_tready;
	assign advance = op inside {OP_NEXT_WORD, OP_NEXT_BYTE, OP_NEXT_INT};
	assign diff    = {{2{max_in[HALF_W-1]}}, max_in} - {{2{min_in[HALF_W-1]}}, min_in}
	                 + {{SPAN_W{1'b0}}, 1'b1};
	assign mul_last = (cnt_q == 2'd3);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		mul_a = seed_q[HALF_W-1:0];
		mul_b = LCG_MULT[HALF_W-1:0];
		case (cnt_q)
			2'd1:    mul_a = seed_q[WORD_W-1:HALF_W];
			2'd2:    mul_b = LCG_MULT[WORD_W-1:HALF_W];
			default: ;
		endcase
	end

	always_comb begin
		if (part_q == 2'd0) begin
			acc_d = acc_q + prod_q;
		end else begin
			acc_d = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && advance) state_d = ST_MUL;
			ST_MUL:  if (mul_last) state_d = empty_q ? ST_DONE : ST_DIV;
			ST_DIV:  if (rem_rsp.done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = acc_d;
		rem_req.divisor  = span_q;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL:  rem_req.start = mul_last && !empty_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (op)
					OP_LOAD_SEED: seed_q <= s_tdata[WORD_W-1:0];
					OP_XOR_SEED:  seed_q <= seed_q ^ s_tdata[WORD_W-1:0];
					default:      ;
				endcase
			end
			if (state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
				if (mul_last) begin
					seed_q <= acc_d;
				end
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && advance) begin
			acc_q   <= LCG_INC;
			lo_q    <= min_in;
			span_q  <= diff[SPAN_W-1:0];
			empty_q <= (max_in <= min_in);
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			part_q <= cnt_q;
			if (cnt_q != 2'd0) begin
				acc_q <= acc_d;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			word_q   <= seed_q;
			byte_q   <= seed_q[10:3];
			ranged_q <= empty_q ? lo_q : lo_q + rem_rsp.remainder;
		end
	end

	lcg_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {ranged_q, byte_q, word_q};

	a_load_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_LOAD_SEED) |=> (seed_q == $past(s_tdata[WORD_W-1:0])))
		else $error("seed load lost");

	a_advance_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == OP_NEXT_WORD || s_tuser == OP_NEXT_BYTE ||
		 s_tuser == OP_NEXT_INT)) |=> !s_tready)
		else $error("ready during advance");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == ST_DIV))
		else $error("remainder finished outside division");

	a_empty_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !empty_q)
		else $error("division started for empty range");

endmodule

// File: rtl/lcg_rem.sv
// ----------------------------------------------------------------------------
// lcg_rem
// Restoring remainder unit: 64-bit dividend by 33-bit divisor, one quotient
// bit per cycle through one shared compare and subtract.
// ----------------------------------------------------------------------------
module lcg_rem
	import lcg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] dividend_q;
	logic [SPAN_W-1:0] divisor_q;
	logic [SPAN_W-1:0] rem_q;

	logic [SPAN_W:0] shifted;
	logic [SPAN_W:0] trial;

	assign shifted = {rem_q, dividend_q[WORD_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[WORD_W-2:0], 1'b0};
			if (trial[SPAN_W]) begin
				rem_q <= shifted[SPAN_W-1:0];
			end else begin
				rem_q <= trial[SPAN_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[HALF_W-1:0];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor_q))
		else $error("remainder not below divisor");

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("done raised while busy");

	a_start_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("start did not begin a division");

endmodule
